>>> rtl/core/spq_pkg.sv
// Package for the stable priority queue: sizes, status codes and the
// per-cell control request type. No dependencies.
`default_nettype none

package spq_pkg;

    localparam int DEPTH      = 16;
    localparam int PRI_LEVELS = 6;
    localparam int VAL_W      = 32;
    localparam int PRI_W      = 3;
    localparam int STAT_W     = 3;
    localparam int CNT_W      = 5;

    localparam logic [STAT_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STAT_W-1:0] ST_REMOVED  = 3'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STAT_W-1:0] ST_BADPRI   = 3'd4;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    typedef struct packed {
        logic             ins;
        logic             rem;
        logic [PRI_W-1:0] pri;
        logic [VAL_W-1:0] val;
    } t_cell_ctl;

endpackage

`default_nettype wire

>>> rtl/core/stable_priority_queue.sv
// Stable priority queue: a chain of DEPTH slots kept sorted by priority.
// The result is registered. Throughput: one insert or remove per cycle
// while the output is not stalled; the output register is freed in the
// same cycle it is taken. Depends on spq_pkg, spq_cell.
// Reset (synchronous, active low) empties the queue and drops the output.
`default_nettype none

module stable_priority_queue import spq_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,  // item_value[31:0], item_priority[34:32]
    input  wire logic        s_axis_tuser,  // mode
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,  // removed_value[31:0], occupancy[36:32]
    output logic [2:0]       m_axis_tuser   // status
);

    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_out_valid;
    logic [STAT_W-1:0] r_status, n_status;
    logic [VAL_W-1:0]  r_rem_val, n_rem_val;

    logic              w_acc;
    logic [VAL_W-1:0]  w_in_val;
    logic [PRI_W-1:0]  w_in_pri;
    t_cell_ctl         w_ctl;

    logic [DEPTH-1:0]  w_gt;
    logic [VAL_W-1:0]  w_val [DEPTH];
    logic [PRI_W-1:0]  w_pri [DEPTH];

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_acc         = s_axis_tvalid && s_axis_tready;
    assign w_in_val      = s_axis_tdata[31:0];
    assign w_in_pri      = s_axis_tdata[34:32];

    always_comb begin
        n_count   = r_count;
        n_status  = ST_INSERTED;
        n_rem_val = '0;
        w_ctl.ins = 1'b0;
        w_ctl.rem = 1'b0;
        w_ctl.pri = w_in_pri;
        w_ctl.val = w_in_val;
        if (s_axis_tuser == MODE_INSERT) begin
            if (w_in_pri >= PRI_W'(PRI_LEVELS)) begin
                n_status = ST_BADPRI;
            end else if (r_count == CNT_W'(DEPTH)) begin
                n_status = ST_FULL;
            end else begin
                n_status  = ST_INSERTED;
                w_ctl.ins = w_acc;
                n_count   = r_count + CNT_W'(1);
            end
        end else begin
            if (r_count == '0) begin
                n_status = ST_EMPTY;
            end else begin
                n_status  = ST_REMOVED;
                n_rem_val = w_val[0];
                w_ctl.rem = w_acc;
                n_count   = r_count - CNT_W'(1);
            end
        end
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic             w_left_gt;
        logic [VAL_W-1:0] w_left_val;
        logic [PRI_W-1:0] w_left_pri;
        logic [VAL_W-1:0] w_right_val;
        logic [PRI_W-1:0] w_right_pri;

        if (i == 0) begin : g_head
            assign w_left_gt  = 1'b0;
            assign w_left_val = '0;
            assign w_left_pri = '0;
        end else begin : g_mid
            assign w_left_gt  = w_gt[i-1];
            assign w_left_val = w_val[i-1];
            assign w_left_pri = w_pri[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            assign w_right_val = '0;
            assign w_right_pri = '0;
        end else begin : g_body
            assign w_right_val = w_val[i+1];
            assign w_right_pri = w_pri[i+1];
        end

        spq_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_occ       (r_count > CNT_W'(i)),
            .i_left_gt   (w_left_gt),
            .i_left_val  (w_left_val),
            .i_left_pri  (w_left_pri),
            .i_right_val (w_right_val),
            .i_right_pri (w_right_pri),
            .o_gt        (w_gt[i]),
            .o_val       (w_val[i]),
            .o_pri       (w_pri[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_acc) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_status  <= n_status;
            r_rem_val <= n_rem_val;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_status;
    assign m_axis_tdata  = {3'b000, r_count, r_rem_val};

endmodule

`default_nettype wire

>>> rtl/core/spq_cell.sv
// One slot of the sorted chain: holds a value and priority, shifts right on
// insert and left on remove. Depends on spq_pkg.
`default_nettype none

module spq_cell import spq_pkg::*; (
    input  wire logic             i_clk,
    input  wire t_cell_ctl        i_ctl,
    input  wire logic             i_occ,
    input  wire logic             i_left_gt,
    input  wire logic [VAL_W-1:0] i_left_val,
    input  wire logic [PRI_W-1:0] i_left_pri,
    input  wire logic [VAL_W-1:0] i_right_val,
    input  wire logic [PRI_W-1:0] i_right_pri,
    output logic                  o_gt,
    output logic [VAL_W-1:0]      o_val,
    output logic [PRI_W-1:0]      o_pri
);

    logic [VAL_W-1:0] r_val, n_val;
    logic [PRI_W-1:0] r_pri, n_pri;

    // slot is empty or ranks strictly behind the new entry
    assign o_gt  = !i_occ || (r_pri > i_ctl.pri);
    assign o_val = r_val;
    assign o_pri = r_pri;

    always_comb begin
        n_val = r_val;
        n_pri = r_pri;
        if (i_ctl.ins && o_gt) begin
            if (i_left_gt) begin
                n_val = i_left_val;
                n_pri = i_left_pri;
            end else begin
                n_val = i_ctl.val;
                n_pri = i_ctl.pri;
            end
        end else if (i_ctl.rem) begin
            n_val = i_right_val;
            n_pri = i_right_pri;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        r_pri <= n_pri;
    end

endmodule

`default_nettype wire

>>> bench/tb.sv
// Testbench for stable_priority_queue: directed and random insert/remove traffic
// checked against an in-bench sorted-queue predictor, with random stalls on both sides.
// Depends on spq_pkg and the stable_priority_queue RTL.
`default_nettype none

module tb import spq_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_PRINTED = 100;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [VAL_W-1:0]  removed_value;
        logic [CNT_W-1:0]  occupancy;
    } queue_result_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    wire logic   s_axis_tready;
    logic [39:0] s_axis_tdata = '0;   // item_value[31:0], item_priority[34:32]
    logic        s_axis_tuser = 1'b0; // mode
    wire logic   m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    wire logic [39:0] m_axis_tdata;   // removed_value[31:0], occupancy[36:32]
    wire logic [2:0]  m_axis_tuser;   // status

    // predictor state
    logic [VAL_W-1:0] held_val [DEPTH];
    logic [PRI_W-1:0] held_pri [DEPTH];
    int               held_count = 0;
    queue_result_t    expected_results [$];

    int error_count  = 0;
    int cycle_count  = 0;
    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    int rx_hold_left = 0;

    stable_priority_queue u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, expected_results.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // result side: long hold-off when requested, random stalls otherwise
    always @(negedge i_clk) begin
        if (rx_hold_left > 0) begin
            m_axis_tready <= 1'b0;
            rx_hold_left--;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic report_mismatch(input string what, input logic [39:0] got,
                                   input logic [39:0] want);
        if (error_count < MAX_PRINTED)
            $display("%0t: %s mismatch: got %h expected %h", $time, what, got, want);
        error_count++;
    endtask

    function automatic void predict_queue_result(input logic mode,
                                                 input logic [VAL_W-1:0] val,
                                                 input logic [PRI_W-1:0] pri);
        queue_result_t res;
        int pos;
        res.status = ST_INSERTED;
        res.removed_value = '0;
        if (mode == MODE_INSERT) begin
            if (pri >= PRI_LEVELS) begin
                res.status = ST_BADPRI;
            end else if (held_count >= DEPTH) begin
                res.status = ST_FULL;
            end else begin
                // stable: goes behind every entry of equal or better priority
                pos = 0;
                while (pos < held_count && held_pri[pos] <= pri)
                    pos++;
                for (int i = held_count; i > pos; i--) begin
                    held_val[i] = held_val[i-1];
                    held_pri[i] = held_pri[i-1];
                end
                held_val[pos] = val;
                held_pri[pos] = pri;
                held_count++;
            end
        end else if (held_count == 0) begin
            res.status = ST_EMPTY;
        end else begin
            res.status = ST_REMOVED;
            res.removed_value = held_val[0];
            for (int i = 1; i < held_count; i++) begin
                held_val[i-1] = held_val[i];
                held_pri[i-1] = held_pri[i];
            end
            held_count--;
        end
        res.occupancy = CNT_W'(held_count);
        expected_results.push_back(res);
    endfunction

    always @(posedge i_clk) begin : check_results
        queue_result_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", m_axis_tdata, '0);
            end else begin
                want = expected_results.pop_front();
                if (m_axis_tuser !== want.status)
                    report_mismatch("status", 40'(m_axis_tuser), 40'(want.status));
                if (m_axis_tdata[31:0] !== want.removed_value)
                    report_mismatch("removed_value", 40'(m_axis_tdata[31:0]),
                                    40'(want.removed_value));
                if (m_axis_tdata[36:32] !== want.occupancy)
                    report_mismatch("occupancy", 40'(m_axis_tdata[36:32]),
                                    40'(want.occupancy));
                if (m_axis_tdata[39:37] !== 3'b000)
                    report_mismatch("tdata padding", m_axis_tdata, '0);
            end
        end
    end

    // one request; returns once it has been taken
    task automatic send_request(input logic mode, input logic [VAL_W-1:0] val,
                                input logic [PRI_W-1:0] pri);
        @(negedge i_clk);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, pri, val};
        s_axis_tuser  <= mode;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_queue_result(mode, val, pri);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'(-$signed({1'b0, $urandom_range(3)}));
            default: return $urandom();
        endcase
    endfunction

    task automatic test_empty_and_bad_priority();
        send_request(MODE_REMOVE, 32'h0, 3'd0);
        send_request(MODE_INSERT, 32'h7FFF_FFFF, 3'd6);
        send_request(MODE_INSERT, 32'h8000_0000, 3'd7);
        drain_results();
    endtask

    task automatic test_fill_to_full();
        logic [VAL_W-1:0] vals [16] = '{
            32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
            32'h0000_0001, 32'hAAAA_AAAA, 32'h5555_5555, 32'h1234_5678,
            32'hDEAD_BEEF, 32'h0000_0002, 32'hFFFF_0000, 32'h0000_FFFF,
            32'h8000_0001, 32'h7FFF_FFFE, 32'hC000_0000, 32'h3FFF_FFFF};
        logic [PRI_W-1:0] pris [16] = '{
            3'd5, 3'd0, 3'd3, 3'd0, 3'd5, 3'd2, 3'd1, 3'd4,
            3'd3, 3'd0, 3'd2, 3'd5, 3'd1, 3'd4, 3'd3, 3'd2};
        for (int i = 0; i < 16; i++)
            send_request(MODE_INSERT, vals[i], pris[i]);
        send_request(MODE_INSERT, 32'h1111_1111, 3'd2);
        // priority check wins over the full check
        send_request(MODE_INSERT, 32'h2222_2222, 3'd7);
        drain_results();
    endtask

    task automatic test_drain_front();
        repeat (4) send_request(MODE_REMOVE, 32'hFFFF_FFFF, 3'd7);
        drain_results();
    endtask

    task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int n_items);
        int insert_bias;
        logic [PRI_W-1:0] pri;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        insert_bias = 50;
        for (int n = 0; n < n_items; n++) begin
            // runs of insert-heavy or remove-heavy traffic reach full and empty
            if (n % 20 == 0) begin
                case ($urandom_range(3))
                    0: insert_bias = 15;
                    1: insert_bias = 50;
                    2: insert_bias = 80;
                    default: insert_bias = 95;
                endcase
            end
            if ($urandom_range(99) < insert_bias) begin
                pri = ($urandom_range(99) < 6) ? 3'(6 + $urandom_range(1))
                                               : 3'($urandom_range(PRI_LEVELS - 1));
                send_request(MODE_INSERT, pick_value(), pri);
            end else begin
                send_request(MODE_REMOVE, $urandom(), 3'($urandom_range(7)));
            end
        end
        drain_results();
    endtask

    task automatic test_output_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        @(posedge i_clk);
        rx_hold_left = 150;
        for (int n = 0; n < 40; n++) begin
            if ($urandom_range(99) < 60)
                send_request(MODE_INSERT, pick_value(), 3'($urandom_range(PRI_LEVELS - 1)));
            else
                send_request(MODE_REMOVE, $urandom(), 3'($urandom_range(7)));
        end
        drain_results();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        tx_idle_pct = 6;
        rx_idle_pct = 64;
        test_empty_and_bad_priority();
        test_fill_to_full();
        test_drain_front();

        test_random_traffic(6, 64, 260);
        test_random_traffic(64, 6, 260);
        test_random_traffic(0, 0, 260);
        test_output_backpressure();

        repeat (10) @(posedge i_clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
